// File: rtl/ujlm_pkg.sv
// shared types and constants for the udp jitter and loss monitor
`timescale 1ns / 1ps

package ujlm_pkg;

    localparam int SEQ_W    = 32;
    localparam int SEC_W    = 32;
    localparam int USEC_W   = 20;
    localparam int LEN_W    = 16;
    localparam int MS_W     = 32;
    localparam int CNT_W    = 32;
    localparam int BYTES_W  = 64;
    localparam int JIT_W    = 36;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 168;

    localparam logic [LEN_W-1:0] MIN_HDR_BYTES = 16'd12;
    localparam logic [31:0]      USEC_PER_MS   = 32'd1000;
    localparam logic [31:0]      USEC_PER_SEC  = 32'd1000000;

    localparam logic [CFG_W-1:0] START_TIME_RESET = 32'd0;
    localparam logic [CFG_W-1:0] DURATION_RESET   = 32'd10000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_TIME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DURATION   = 1'b1;

    // one packet after the transit stage
    typedef struct packed {
        logic             ok;
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
        logic [MS_W-1:0]  now;
        logic [31:0]      transit;
    } item_t;

endpackage

// File: rtl/ujlm_transit.sv
// input register and transit time stage of the monitor
`timescale 1ns / 1ps

module ujlm_transit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // seq_number, sent_sec, sent_usec, pkt_length, now_ms, zero pad
    input  logic [ujlm_pkg::IN_DATA_W-1:0]    s_tdata,
    output ujlm_pkg::item_t                   item,
    output logic                              item_valid,
    input  logic                              item_ready
);

    logic                          a_valid_reg;
    logic [ujlm_pkg::SEQ_W-1:0]    a_seq_reg;
    logic [ujlm_pkg::SEC_W-1:0]    a_sec_reg;
    logic [ujlm_pkg::USEC_W-1:0]   a_usec_reg;
    logic [ujlm_pkg::LEN_W-1:0]    a_len_reg;
    logic [ujlm_pkg::MS_W-1:0]     a_now_reg;

    logic                          b_valid_reg;
    ujlm_pkg::item_t               b_item_reg;
    ujlm_pkg::item_t               b_item_next;

    logic                          a_ready;
    logic                          b_ready;
    logic                          a_load;
    logic                          b_load;
    logic [31:0]                   now_us;
    logic [31:0]                   sent_us;

    assign b_ready  = !b_valid_reg || item_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign s_tready = a_ready;
    assign a_load   = s_tvalid && a_ready;
    assign b_load   = a_valid_reg && b_ready;

    // transit in microseconds, all mod 2^32
    assign now_us  = a_now_reg * ujlm_pkg::USEC_PER_MS;
    assign sent_us = a_sec_reg * ujlm_pkg::USEC_PER_SEC + {12'd0, a_usec_reg};

    always_comb
    begin
        b_item_next.ok      = (a_len_reg >= ujlm_pkg::MIN_HDR_BYTES);
        b_item_next.seq     = a_seq_reg;
        b_item_next.len     = a_len_reg;
        b_item_next.now     = a_now_reg;
        b_item_next.transit = now_us - sent_us;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= s_tvalid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_seq_reg  <= s_tdata[31:0];
            a_sec_reg  <= s_tdata[63:32];
            a_usec_reg <= s_tdata[83:64];
            a_len_reg  <= s_tdata[99:84];
            a_now_reg  <= s_tdata[131:100];
        end
        if (b_load)
        begin
            b_item_reg <= b_item_next;
        end
    end

    assign item       = b_item_reg;
    assign item_valid = b_valid_reg;

endmodule

// File: rtl/ujlm_stats.sv
// statistics state, configuration registers and result register
`timescale 1ns / 1ps

module ujlm_stats
#(
    parameter int JITTER_SHIFT = 4
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ujlm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ujlm_pkg::CFG_W-1:0]         cfg_wdata,
    input  ujlm_pkg::item_t                    item,
    input  logic                               item_valid,
    output logic                               item_ready,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // rx_packets, lost_packets, rx_bytes, jitter_x16_us, test_done, zero pad
    output logic [ujlm_pkg::OUT_DATA_W-1:0]    m_tdata,
    // accepted
    output logic                               m_tuser
);

    localparam int JIT_W = ujlm_pkg::JIT_W;

    logic [ujlm_pkg::CFG_W-1:0]    start_reg;
    logic [ujlm_pkg::CFG_W-1:0]    duration_reg;

    logic [ujlm_pkg::SEQ_W-1:0]    nexp_reg,    nexp_next;
    logic [31:0]                   transit_reg, transit_next;
    logic [JIT_W-1:0]              jit_reg,     jit_next;
    logic [ujlm_pkg::CNT_W-1:0]    pkt_reg,     pkt_next;
    logic [ujlm_pkg::CNT_W-1:0]    loss_reg,    loss_next;
    logic [ujlm_pkg::BYTES_W-1:0]  bytes_reg,   bytes_next;
    logic                          done_reg,    done_next;

    logic                          m_valid_reg;
    logic                          m_acc_reg;
    logic [ujlm_pkg::OUT_DATA_W-1:0] m_data_reg;

    logic                          fire;
    logic [31:0]                   diff;
    logic [31:0]                   mag;
    logic [JIT_W:0]                jit_sum;
    logic [ujlm_pkg::MS_W-1:0]     elapsed;

    assign item_ready = !m_valid_reg || m_tready;
    assign fire       = item_valid && item_ready;

    assign diff    = item.transit - transit_reg;
    // 0x80000000 negates to itself, which is the wanted magnitude
    assign mag     = diff[31] ? (32'd0 - diff) : diff;
    assign jit_sum = {1'b0, jit_reg} - ({1'b0, jit_reg} >> JITTER_SHIFT)
                     + {{(JIT_W - 31){1'b0}}, mag};
    assign elapsed = item.now - start_reg;

    always_comb
    begin
        nexp_next    = nexp_reg;
        transit_next = transit_reg;
        jit_next     = jit_reg;
        pkt_next     = pkt_reg;
        loss_next    = loss_reg;
        bytes_next   = bytes_reg;
        done_next    = done_reg;
        if (item.ok)
        begin
            pkt_next   = pkt_reg + 32'd1;
            bytes_next = bytes_reg + {48'd0, item.len};
            // zero expectation means no packet seen yet
            if ((nexp_reg != 32'd0) && (item.seq > nexp_reg))
            begin
                loss_next = loss_reg + (item.seq - nexp_reg);
            end
            nexp_next = item.seq + 32'd1;
            if (transit_reg != 32'd0)
            begin
                jit_next = jit_sum[JIT_W] ? {JIT_W{1'b1}} : jit_sum[JIT_W-1:0];
            end
            transit_next = item.transit;
            if (elapsed >= duration_reg)
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg    <= ujlm_pkg::START_TIME_RESET;
            duration_reg <= ujlm_pkg::DURATION_RESET;
            nexp_reg     <= '0;
            transit_reg  <= '0;
            jit_reg      <= '0;
            pkt_reg      <= '0;
            loss_reg     <= '0;
            bytes_reg    <= '0;
            done_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ujlm_pkg::REG_START_TIME: start_reg    <= cfg_wdata;
                    ujlm_pkg::REG_DURATION:   duration_reg <= cfg_wdata;
                    default:                  ;
                endcase
            end
            if (fire)
            begin
                nexp_reg    <= nexp_next;
                transit_reg <= transit_next;
                jit_reg     <= jit_next;
                pkt_reg     <= pkt_next;
                loss_reg    <= loss_next;
                bytes_reg   <= bytes_next;
                done_reg    <= done_next;
            end
            if (item_ready)
            begin
                m_valid_reg <= item_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            m_acc_reg  <= item.ok;
            m_data_reg <= {3'd0, done_next, jit_next, bytes_next, loss_next, pkt_next};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_acc_reg;

`ifndef ASSERT_OFF
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg)
        else $error("done flag cleared");

    a_pkt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.ok) |=> (pkt_reg == $past(pkt_reg) + 32'd1))
        else $error("packet count did not step on a counted packet");

    a_short_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !item.ok) |=> ($stable(pkt_reg) && $stable(bytes_reg)
                               && $stable(loss_reg) && $stable(jit_reg)))
        else $error("short packet changed the statistics");

    a_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> ($stable(nexp_reg) && $stable(transit_reg) && $stable(loss_reg)))
        else $error("state changed with no request consumed");
`endif

endmodule

// File: rtl/udp_jitter_loss_monitor.sv
// udp receive monitor: packet, byte and loss counters with interarrival jitter
// pipeline: input register, transit stage register, then the result register
// throughput: one request per cycle unless m_tready stalls; per-packet state
// updates loop in the statistics stage, the transit multiply has its own stage
// reset: asynchronous active-low rst_n clears all counters, the done flag and
// the pipeline valids; start time returns to 0 and duration to 10000 ms
`timescale 1ns / 1ps

module udp_jitter_loss_monitor
#(
    parameter int JITTER_SHIFT = 4
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ujlm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ujlm_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // seq_number, sent_sec, sent_usec, pkt_length, now_ms, zero pad
    input  logic [ujlm_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // rx_packets, lost_packets, rx_bytes, jitter_x16_us, test_done, zero pad
    output logic [ujlm_pkg::OUT_DATA_W-1:0]    m_tdata,
    // accepted
    output logic                               m_tuser
);

    ujlm_pkg::item_t item;
    logic            item_valid;
    logic            item_ready;

    ujlm_transit u_transit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready)
    );

    ujlm_stats
    #(
        .JITTER_SHIFT (JITTER_SHIFT)
    )
    u_stats
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
